// ----- rtl/asert_difficulty_target_assert.svh -----
// Assertion macros for the difficulty target block.
// Used by adt_fifo; clocked on aclk, disabled in reset.
`ifndef ASERT_DIFFICULTY_TARGET_ASSERT_SVH
`define ASERT_DIFFICULTY_TARGET_ASSERT_SVH
`ifndef SYNTH
`define ADT_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("adt assertion failed");
`define ADT_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("adt assertion failed");
`else
`define ADT_ASSERT_IMP(lbl, pre, post)
`define ADT_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ----- rtl/adt_pkg.sv -----
// Shared types and constants of the difficulty target block.
// No dependencies; imported by every module.
package adt_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int TARGET_WIDTH_DEF = 256;
    localparam int HEIGHT_W         = 31;
    localparam int TIME_W           = 32;
    localparam int BITS_W           = 32;
    localparam int SPACING_W        = 21;
    localparam int HL_W             = 32;
    // |dt - spacing*(dh+1)| stays below 2^53
    localparam int MAG_W            = 53;
    localparam int DIV_W            = MAG_W + FRAC_BITS;
    localparam int FIFO_DEPTH       = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [63:0] CUBIC_C1  = 64'd195766423245049;
    localparam logic [63:0] CUBIC_C2  = 64'd971821376;
    localparam logic [63:0] CUBIC_C3  = 64'd5127;
    localparam logic [63:0] CUBIC_RND = 64'h0000_8000_0000_0000;
    localparam logic [16:0] FACTOR_ONE = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANCHOR_HEIGHT = 3'd0,
        CFG_ANCHOR_TIME   = 3'd1,
        CFG_ANCHOR_BITS   = 3'd2,
        CFG_LIMIT_BITS    = 3'd3,
        CFG_SPACING       = 3'd4,
        CFG_HALF_LIFE     = 3'd5,
        CFG_FIXED_MODE    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0]  anc_height;
        logic [TIME_W-1:0]    anchor_time;
        logic [SPACING_W-1:0] block_spacing;
        logic [HL_W-1:0]      hl_secs;
        logic                 fixed_mode;
    } cfg_t;

    typedef struct packed {
        logic             early;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } item_t;

    typedef struct packed {
        logic             early;
        logic             neg;
        logic [DIV_W-1:0] quot;
    } div_res_t;

endpackage

// ----- rtl/adt_front.sv -----
// Front end: input register and classification into queue items.
// Depends on adt_pkg.
module adt_front import adt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg_i,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                no_parent,
    input  logic [HEIGHT_W-1:0] parent_height,
    input  logic [TIME_W-1:0]   parent_time,
    input  logic                full_i,
    output logic                push_o,
    output item_t               item_o
);

    logic                f_valid_reg, f_valid_next;
    logic                np_reg;
    logic [HEIGHT_W-1:0] ph_reg;
    logic [TIME_W-1:0]   pt_reg;
    logic                accept;

    logic signed [32:0]  dt;
    logic [31:0]         dh1;
    logic [52:0]         prod;
    logic [53:0]         base;
    logic [53:0]         nbase;

    assign s_ready = !f_valid_reg || !full_i;
    assign accept  = s_valid && s_ready;
    assign push_o  = f_valid_reg && !full_i;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (push_o) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            np_reg <= no_parent;
            ph_reg <= parent_height;
            pt_reg <= parent_time;
        end
    end

    // base = dt - spacing * (dh + 1), then split into sign and magnitude
    assign dt    = $signed({1'b0, pt_reg}) - $signed({1'b0, cfg_i.anchor_time});
    assign dh1   = {1'b0, ph_reg} - {1'b0, cfg_i.anc_height} + 32'd1;
    assign prod  = 53'(cfg_i.block_spacing) * 53'(dh1);
    assign base  = {{21{dt[32]}}, dt} - {1'b0, prod};
    assign nbase = 54'd0 - base;

    assign item_o.early = np_reg || cfg_i.fixed_mode || (ph_reg < cfg_i.anc_height)
                          || (cfg_i.hl_secs == '0);
    assign item_o.neg   = base[53];
    assign item_o.mag   = base[53] ? nbase[MAG_W-1:0] : base[MAG_W-1:0];

endmodule

// ----- rtl/adt_fifo.sv -----
// Short queue of classified items between front end and divider.
// Depends on adt_pkg and the assertion header.
`include "asert_difficulty_target_assert.svh"
module adt_fifo import adt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_i,
    input  item_t push_item_i,
    input  logic  pop_i,
    output item_t pop_item_o,
    output logic  full_o,
    output logic  empty_o
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    item_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full_o     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty_o    = (count_reg == '0);
    assign pop_item_o = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push_i && !pop_i) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_i && !push_i) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_i) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop_i) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= push_item_i;
        end
    end

    `ADT_ASSERT_IMP(a_cnt_range, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH))
    `ADT_ASSERT_IMP(a_pop_nonempty, pop_i, count_reg != '0)
    `ADT_ASSERT_NXT(a_push_grows, push_i && !pop_i, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

// ----- rtl/adt_div.sv -----
// Pipelined restoring divider: (magnitude << 16) / half-life period, one quotient bit a stage.
// Depends on adt_pkg.
module adt_div import adt_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv_i,
    input  logic            in_valid_i,
    input  item_t           in_item_i,
    input  logic [HL_W-1:0] hl_secs_i,
    output logic            out_valid_o,
    output div_res_t        out_o
);

    localparam int NST = DIV_W + 1;

    logic [NST-1:0]   v_reg;
    logic [NST-1:0]   early_reg;
    logic [NST-1:0]   neg_reg;
    logic [HL_W-1:0]  rem_reg [NST];
    logic [DIV_W-1:0] dq_reg  [NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv_i) begin
            v_reg <= {v_reg[NST-2:0], in_valid_i};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_i) begin
            early_reg <= {early_reg[NST-2:0], in_item_i.early};
            neg_reg   <= {neg_reg[NST-2:0], in_item_i.neg};
            rem_reg[0] <= '0;
            dq_reg[0]  <= {in_item_i.mag, FRAC_BITS'(0)};
        end
    end

    // shift the dividend out of the top while quotient bits enter the bottom
    for (genvar s = 1; s < NST; s++) begin : g_stage
        logic [HL_W:0] t;
        logic [HL_W:0] diff;
        logic          ge;

        assign t    = {rem_reg[s-1], dq_reg[s-1][DIV_W-1]};
        assign diff = t - {1'b0, hl_secs_i};
        assign ge   = (t >= {1'b0, hl_secs_i});

        always_ff @(posedge aclk) begin
            if (adv_i) begin
                rem_reg[s] <= ge ? diff[HL_W-1:0] : t[HL_W-1:0];
                dq_reg[s]  <= {dq_reg[s-1][DIV_W-2:0], ge};
            end
        end
    end

    assign out_valid_o = v_reg[NST-1];
    assign out_o.early = early_reg[NST-1];
    assign out_o.neg   = neg_reg[NST-1];
    assign out_o.quot  = dq_reg[NST-1];

endmodule

// ----- rtl/adt_back.sv -----
// Back end: exponent split, cubic factor, target scaling, clamp and compact encoding.
// Depends on adt_pkg; drives the result register.
module adt_back import adt_pkg::*; #(
    parameter int TARGET_WIDTH = TARGET_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid_i,
    input  div_res_t                in_i,
    input  logic [TARGET_WIDTH-1:0] lim_i,
    input  logic [TARGET_WIDTH-1:0] ref_i,
    output logic                    adv_o,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [BITS_W-1:0]       m_data
);

    localparam int TW    = TARGET_WIDTH;
    localparam int NLANE = (TW + 31) / 32;
    localparam int LW    = 32 * NLANE;
    localparam int VW    = LW + 32;
    localparam int SA_W  = $clog2(VW);
    localparam int NB    = (TW + 7) / 8;
    localparam int BW    = 8 * NB;
    localparam int SZ_W  = $clog2(NB + 1);

    logic [9:0] v_reg;
    logic       m_valid_reg;
    logic [BITS_W-1:0] m_data_reg, m_data_next;

    assign adv_o   = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv_o) begin
            v_reg       <= {v_reg[8:0], in_valid_i};
            m_valid_reg <= v_reg[9];
        end
    end

    // S1: saturate the quotient into a signed exponent
    logic        sat;
    logic [63:0] q64, nq64, e;
    logic [48:0] sh1;
    logic        s1_early;
    logic [15:0] s1_frac;
    logic [48:0] s1_sh;

    assign sat  = |in_i.quot[DIV_W-1:63];
    assign q64  = in_i.quot[63:0];
    assign nq64 = 64'd0 - q64;
    always_comb begin
        if (in_i.neg) begin
            e = sat ? 64'h8000_0000_0000_0000 : nq64;
        end else begin
            e = sat ? 64'h7fff_ffff_ffff_ffff : q64;
        end
    end
    assign sh1 = {e[63], e[63:FRAC_BITS]} - 49'd16;

    // S2 .. S4: cubic approximation of 2^frac
    logic [15:0] s2_frac;
    logic [31:0] s2_f2;
    logic [63:0] s2_t1;
    logic        s2_early;
    logic [48:0] s2_sh;
    logic [47:0] s3_f3;
    logic [63:0] s3_t1, s3_t2;
    logic        s3_early;
    logic [48:0] s3_sh;
    logic [63:0] t3c, sum4;
    logic [16:0] s4_factor;
    logic        s4_early;
    logic [48:0] s4_sh;

    assign t3c  = CUBIC_C3 * {16'b0, s3_f3};
    assign sum4 = s3_t1 + s3_t2 + t3c + CUBIC_RND;

    // S5, S6: scale the anchor target by the factor in 32-bit lanes
    logic [LW-1:0] ref_pad;
    logic [48:0]   s5_pp [NLANE];
    logic          s5_early;
    logic [48:0]   s5_sh;
    logic [VW-1:0] evn, odd;
    logic          left6, rzero6, lbig6;
    logic [48:0]   nsh6;
    logic [VW-1:0] s6_val;
    logic          s6_left, s6_rzero, s6_lbig, s6_early;
    logic [SA_W-1:0] s6_amt, s6_lamt;

    assign ref_pad = LW'(ref_i);

    always_comb begin
        evn = '0;
        odd = '0;
        for (int i = 0; i < NLANE; i++) begin
            if (i % 2 == 0) begin
                evn[32*i +: 49] = s5_pp[i];
            end else begin
                odd[32*i +: 49] = s5_pp[i];
            end
        end
    end

    assign left6  = $signed(s5_sh) > 49'sd0;
    assign nsh6   = 49'd0 - s5_sh;
    assign rzero6 = !left6 && (nsh6 >= 49'(VW));
    assign lbig6  = left6 && ($signed(s5_sh) > $signed(49'(TW)));

    // S7: apply the integer part of the exponent
    logic [VW-1:0] res7;
    logic          sel7;
    logic [VW-1:0] s7_res;
    logic          s7_sel;

    always_comb begin
        res7 = '0;
        sel7 = s6_early;
        if (s6_left) begin
            res7 = s6_val << s6_amt;
            if (s6_lbig || ((s6_val >> s6_lamt) != '0)) begin
                sel7 = 1'b1;
            end
        end else if (!s6_rzero) begin
            res7 = s6_val >> s6_amt;
        end
    end

    // S8: clamp to [1, limit]; a limit answer chosen by s7_sel goes out as it is, even when zero
    logic [TW-1:0] cand8, fin8;
    logic [TW-1:0] s8_val;

    assign cand8 = (s7_sel || (s7_res > VW'(lim_i))) ? lim_i : s7_res[TW-1:0];
    assign fin8  = (!s7_sel && (cand8 == '0)) ? TW'(1) : cand8;

    // S9, S10: locate the highest non-zero byte
    logic [BW-1:0] pad9;
    logic [NB-1:0] flg9;
    logic [BW-1:0] s9_val;
    logic [NB-1:0] s9_flg;
    logic [SZ_W-1:0] size10;
    logic [BW-1:0]   s10_val;
    logic [SZ_W-1:0] s10_size;

    assign pad9 = BW'(s8_val);
    always_comb begin
        for (int b = 0; b < NB; b++) begin
            flg9[b] = |pad9[8*b +: 8];
        end
    end

    always_comb begin
        size10 = '0;
        for (int b = 0; b < NB; b++) begin
            if (s9_flg[b]) begin
                size10 = SZ_W'(b + 1);
            end
        end
    end

    // S11: take three bytes under the size and normalise the sign bit
    logic [BW+23:0] ap11;
    logic [23:0]    c11;
    logic [7:0]     size11;

    assign ap11 = {s10_val, 24'b0};
    always_comb begin
        c11    = ap11[{s10_size, 3'b0} +: 24];
        size11 = 8'(s10_size);
        if (c11[23]) begin
            c11    = c11 >> 8;
            size11 = size11 + 8'd1;
        end
        m_data_next = {size11, c11};
    end

    always_ff @(posedge aclk) begin
        if (adv_o) begin
            s1_early <= in_i.early || (ref_i == '0) || (ref_i > lim_i);
            s1_frac  <= e[15:0];
            s1_sh    <= sh1;

            s2_frac  <= s1_frac;
            s2_f2    <= 32'(s1_frac) * 32'(s1_frac);
            s2_t1    <= CUBIC_C1 * {48'b0, s1_frac};
            s2_early <= s1_early;
            s2_sh    <= s1_sh;

            s3_f3    <= {16'b0, s2_f2} * {32'b0, s2_frac};
            s3_t1    <= s2_t1;
            s3_t2    <= CUBIC_C2 * {32'b0, s2_f2};
            s3_early <= s2_early;
            s3_sh    <= s2_sh;

            s4_factor <= FACTOR_ONE + {1'b0, sum4[63:48]};
            s4_early  <= s3_early;
            s4_sh     <= s3_sh;

            for (int i = 0; i < NLANE; i++) begin
                s5_pp[i] <= 49'(ref_pad[32*i +: 32]) * 49'(s4_factor);
            end
            s5_early <= s4_early;
            s5_sh    <= s4_sh;

            s6_val   <= evn + odd;
            s6_left  <= left6;
            s6_rzero <= rzero6;
            s6_lbig  <= lbig6;
            s6_amt   <= left6 ? s5_sh[SA_W-1:0] : nsh6[SA_W-1:0];
            s6_lamt  <= SA_W'(TW) - s5_sh[SA_W-1:0];
            s6_early <= s5_early;

            s7_res <= res7;
            s7_sel <= sel7;

            s8_val <= fin8;

            s9_val <= pad9;
            s9_flg <= flg9;

            s10_val  <= s9_val;
            s10_size <= size10;

            m_data_reg <= m_data_next;
        end
    end

endmodule

// ----- rtl/asert_difficulty_target.sv -----
// Top level of the ASERT difficulty target block: config registers and the
// front / queue / divider / back chain. Depends on adt_pkg and all adt_ modules.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tuser: no_parent; s_tdata: parent_height, parent_time
//  m_       out  m_tvalid/m_tready    m_tdata: next_bits
//  cfg_     in   cfg_we               cfg_addr: register index; cfg_wdata: value
//
// One transfer in and one out per cycle, sustained while m_tready stays high. m_tvalid
// rises after the input transfer has passed the front register, the queue, the divider
// and the back end (10 stages plus the output register).
// Reset clears valid state and loads register defaults; no clearing pass.
// A stalled m_ side holds the back end; the four-entry queue then fills and
// s_tready drops.
module asert_difficulty_target import adt_pkg::*; #(
    parameter int TARGET_WIDTH = TARGET_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // parent_height [30:0], parent_time [62:31]
    input  logic [0:0]            s_tuser,   // no_parent [0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata    // next_bits [31:0]
);

    localparam int TW = TARGET_WIDTH;

    logic [HEIGHT_W-1:0]  anc_height_reg;
    logic [TIME_W-1:0]    anchor_time_reg;
    logic [BITS_W-1:0]    anchor_bits_reg;
    logic [BITS_W-1:0]    limit_bits_reg;
    logic [SPACING_W-1:0] spacing_reg;
    logic [HL_W-1:0]      hl_secs_reg;
    logic                 fixed_mode_reg;
    logic [TW-1:0]        dec_lim_reg, dec_ref_reg;

    cfg_t     cfg;
    logic     push, full, empty, pop, adv;
    item_t    push_item, pop_item;
    logic     div_valid;
    div_res_t div_res;

    function automatic logic [TW-1:0] decode_compact(input logic [31:0] bits);
        logic [7:0]    size;
        logic [7:0]    up;
        logic [TW-1:0] v;
        size = bits[31:24];
        up   = size - 8'd3;
        if (size <= 8'd3) begin
            v = TW'(bits[22:0] >> {2'(3 - size[1:0]), 3'b0});
        end else begin
            v = TW'(bits[22:0]) << {up, 3'b0};
        end
        return v;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anc_height_reg  <= HEIGHT_W'(1);
            anchor_time_reg <= '0;
            anchor_bits_reg <= '0;
            limit_bits_reg  <= '0;
            spacing_reg     <= SPACING_W'(120);
            hl_secs_reg     <= HL_W'(172800);
            fixed_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_ANCHOR_HEIGHT: anc_height_reg  <= cfg_wdata[HEIGHT_W-1:0];
                CFG_ANCHOR_TIME:   anchor_time_reg <= cfg_wdata[TIME_W-1:0];
                CFG_ANCHOR_BITS:   anchor_bits_reg <= cfg_wdata[BITS_W-1:0];
                CFG_LIMIT_BITS:    limit_bits_reg  <= cfg_wdata[BITS_W-1:0];
                CFG_SPACING:       spacing_reg     <= cfg_wdata[SPACING_W-1:0];
                CFG_HALF_LIFE:     hl_secs_reg     <= cfg_wdata[HL_W-1:0];
                CFG_FIXED_MODE:    fixed_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // decoded targets follow the registers in the next cycle, long before the back end reads them
    always_ff @(posedge aclk) begin
        dec_lim_reg <= decode_compact(limit_bits_reg);
        dec_ref_reg <= decode_compact(anchor_bits_reg);
    end

    assign cfg.anc_height    = anc_height_reg;
    assign cfg.anchor_time   = anchor_time_reg;
    assign cfg.block_spacing = spacing_reg;
    assign cfg.hl_secs       = hl_secs_reg;
    assign cfg.fixed_mode    = fixed_mode_reg;

    assign pop = adv && !empty;

    adt_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_i         (cfg),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .no_parent     (s_tuser[0]),
        .parent_height (s_tdata[30:0]),
        .parent_time   (s_tdata[62:31]),
        .full_i        (full),
        .push_o        (push),
        .item_o        (push_item)
    );

    adt_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (push),
        .push_item_i (push_item),
        .pop_i       (pop),
        .pop_item_o  (pop_item),
        .full_o      (full),
        .empty_o     (empty)
    );

    adt_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv_i       (adv),
        .in_valid_i  (pop),
        .in_item_i   (pop_item),
        .hl_secs_i   (hl_secs_reg),
        .out_valid_o (div_valid),
        .out_o       (div_res)
    );

    adt_back #(
        .TARGET_WIDTH (TARGET_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid_i (div_valid),
        .in_i       (div_res),
        .lim_i      (dec_lim_reg),
        .ref_i      (dec_ref_reg),
        .adv_o      (adv),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_tdata)
    );

endmodule
